### rtl/cfcs_pkg.sv
// cfcs_pkg: shared sizes, register indexes, queue entry type and the
// output saturation helper for the crossfade channel switch.
// No dependencies.
package cfcs_pkg;

  localparam int CHANNELS       = 5;
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int GAIN_W = GAIN_FRAC_BITS + 1;
  localparam int STEP_W = 17;
  localparam int CH_W   = $clog2(CHANNELS);
  localparam int SEL_W  = 3;
  // compare width for the clamped gain update
  localparam int CW     = ((GAIN_W > STEP_W) ? GAIN_W : STEP_W) + 1;

  localparam int DATA_W  = CHANNELS * SAMPLE_BITS;
  localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int PW     = PROD_W - GAIN_FRAC_BITS;
  localparam int SUM_W  = PW + CH_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP = 1'd1;

  localparam logic DIR_MUX   = 1'b0;
  localparam logic DIR_DEMUX = 1'b1;

  localparam logic [STEP_W-1:0] SLEW_STEP_RESET = STEP_W'(34);
  localparam logic [CW-1:0]     GAIN_FULL       = CW'(1) << GAIN_FRAC_BITS;

  typedef struct packed {
    logic [CHANNELS-1:0][GAIN_W-1:0]      gain;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] smp;
    logic [CH_W-1:0]                      sel;
  } cfcs_entry_t;

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed(SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1));
    lo = -hi - SUM_W'(1);
    if (x > hi) begin
      sat_sample = hi[SAMPLE_BITS-1:0];
    end else if (x < lo) begin
      sat_sample = lo[SAMPLE_BITS-1:0];
    end else begin
      sat_sample = x[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

### rtl/cfcs_front.sv
// cfcs_front: input side. Detects button edges, keeps the selection and
// slews the per-channel gains, then hands the beat to the queue.
// Depends on cfcs_pkg.
module cfcs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cfcs_pkg::STEP_W-1:0] slew_step,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cfcs_pkg::CHANNELS-1:0] buttons,
  input  logic [cfcs_pkg::DATA_W-1:0] samples,
  output logic                        push_valid,
  input  logic                        push_ready,
  output cfcs_pkg::cfcs_entry_t       push_data
);
  import cfcs_pkg::*;

  logic [CHANNELS-1:0]             btn_prev_r;
  logic [CH_W-1:0]                 cur_r, cur_nxt;
  logic [CHANNELS-1:0][GAIN_W-1:0] gain_r, gain_nxt;
  logic [CHANNELS-1:0]             rising;
  logic [CW-1:0]                   step_ext;
  logic [CW-1:0]                   g_ext;
  logic                            accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign rising     = buttons & ~btn_prev_r;
  assign step_ext   = CW'(slew_step);

  always_comb begin
    cur_nxt = cur_r;
    // highest rising index wins
    for (int i = 0; i < CHANNELS; i++) begin
      if (rising[i]) begin
        cur_nxt = CH_W'(i);
      end
    end
    for (int i = 0; i < CHANNELS; i++) begin
      g_ext = CW'(gain_r[i]);
      if (CH_W'(i) == cur_nxt) begin
        if ((GAIN_FULL - g_ext) > step_ext) begin
          gain_nxt[i] = GAIN_W'(g_ext + step_ext);
        end else begin
          gain_nxt[i] = GAIN_FULL[GAIN_W-1:0];
        end
      end else begin
        if (g_ext > step_ext) begin
          gain_nxt[i] = GAIN_W'(g_ext - step_ext);
        end else begin
          gain_nxt[i] = '0;
        end
      end
    end
  end

  assign push_data.gain = gain_nxt;
  assign push_data.smp  = samples;
  assign push_data.sel  = cur_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_prev_r <= '0;
      cur_r      <= '0;
      gain_r     <= '0;
    end else if (accept) begin
      btn_prev_r <= buttons;
      cur_r      <= cur_nxt;
      gain_r     <= gain_nxt;
    end
  end

endmodule

### rtl/cfcs_queue.sv
// cfcs_queue: two-entry queue between the gain front end and the
// multiply back end. Depends on cfcs_pkg.
module cfcs_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  cfcs_pkg::cfcs_entry_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output cfcs_pkg::cfcs_entry_t pop_data
);
  import cfcs_pkg::*;

  cfcs_entry_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push, pop;

  assign push_ready = (count_r != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

### rtl/cfcs_back.sv
// cfcs_back: gain multiply stage, then mix/saturate into the output
// register. Depends on cfcs_pkg.
module cfcs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  direction,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  cfcs_pkg::cfcs_entry_t pop_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [cfcs_pkg::DATA_W-1:0] out_data,
  output logic [cfcs_pkg::SEL_W-1:0]  out_sel
);
  import cfcs_pkg::*;

  logic                                 a_v_r;
  logic [CHANNELS-1:0][PW-1:0]          prod_r, prod_nxt;
  logic [CH_W-1:0]                      a_sel_r;
  logic                                 o_v_r;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] o_data_r, o_data_nxt;
  logic [SEL_W-1:0]                     o_sel_r;
  logic signed [PROD_W-1:0]             full_prod [CHANNELS];
  logic signed [SUM_W-1:0]              sum;
  logic                                 b_ready, a_ready;

  assign b_ready   = !o_v_r || out_ready;
  assign a_ready   = !a_v_r || b_ready;
  assign pop_ready = a_ready;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (direction == DIR_DEMUX) begin
        full_prod[i] = $signed(pop_data.smp[0]) * $signed({1'b0, pop_data.gain[i]});
      end else begin
        full_prod[i] = $signed(pop_data.smp[i]) * $signed({1'b0, pop_data.gain[i]});
      end
      prod_nxt[i] = PW'(full_prod[i] >>> GAIN_FRAC_BITS);
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sum = sum + SUM_W'($signed(prod_r[i]));
    end
    o_data_nxt = '0;
    if (direction == DIR_DEMUX) begin
      for (int i = 0; i < CHANNELS; i++) begin
        o_data_nxt[i] = sat_sample(SUM_W'($signed(prod_r[i])));
      end
    end else begin
      o_data_nxt[0] = sat_sample(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && pop_valid) begin
      prod_r  <= prod_nxt;
      a_sel_r <= pop_data.sel;
    end
    if (b_ready && a_v_r) begin
      o_data_r <= o_data_nxt;
      o_sel_r  <= SEL_W'(a_sel_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_r <= pop_valid;
      end
      if (b_ready) begin
        o_v_r <= a_v_r;
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_data_r;
  assign out_sel   = o_sel_r;

endmodule

### rtl/crossfade_channel_switch.sv
// crossfade_channel_switch: top level; configuration registers and the
// front / queue / back chain. Depends on cfcs_pkg and the cfcs_* modules.
//
// Click-free five-channel selector. One beat is taken every clock as long
// as the output side keeps up. The gain slew is combinational and writes
// the queue at the accepting edge. After that come the 24x17 gain
// multipliers into the product register, then the mix and saturation
// into the output register.
// A rising button edge selects a channel, the highest index winning; each
// beat slews every gain by slew_step toward full scale (selected) or zero.
// direction 0 mixes all samples onto out_0, 1 scales sample_0 to every
// output. Write configuration only while no beat is in flight.
module crossfade_channel_switch (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfcs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_0 .. sample_4, 24 bits each from bit 0
  input  logic [cfcs_pkg::TDATA_W-1:0]      in_tdata,
  // select_buttons
  input  logic [cfcs_pkg::CHANNELS-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_0 .. out_4, 24 bits each from bit 0
  output logic [cfcs_pkg::TDATA_W-1:0]      out_tdata,
  // selected
  output logic [cfcs_pkg::SEL_W-1:0]        out_tuser
);
  import cfcs_pkg::*;

  logic              direction_r;
  logic [STEP_W-1:0] slew_step_r;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  cfcs_entry_t       push_data, pop_data;
  logic [DATA_W-1:0] out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_MUX;
      slew_step_r <= SLEW_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: direction_r <= cfg_wdata[0];
        CFG_SLEW_STEP: slew_step_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  cfcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .slew_step  (slew_step_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .buttons    (in_tuser),
    .samples    (in_tdata[DATA_W-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cfcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cfcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (direction_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data),
    .out_sel   (out_tuser)
  );

  assign out_tdata = TDATA_W'(out_data);

endmodule

### tb/crossfade_channel_switch_test.sv
// crossfade_channel_switch_test: self-checking bench for the click-free channel selector.
// Drives button/sample beats with random pacing and keeps a slew/mix model of its own.
// Depends on cfcs_pkg and the crossfade_channel_switch RTL.
`timescale 1ns / 100ps

module crossfade_channel_switch_test;
  import cfcs_pkg::*;

  localparam int GAIN_ONE = 1 << GAIN_FRAC_BITS;
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [CHANNELS-1:0]                  buttons;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] smp;
  } frame_t;

  typedef struct packed {
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] outs;
    logic [SEL_W-1:0]                     sel;
  } mix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata = '0;
  logic [CHANNELS-1:0]   in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic [SEL_W-1:0]      out_tuser;

  // model state
  logic [SEL_W-1:0]    pick = '0;
  int                  gain_q16 [CHANNELS] = '{default: 0};
  logic [CHANNELS-1:0] buttons_prev = '0;
  logic                direction_now = DIR_MUX;
  int                  step_now = 34;

  mix_t expected_mix[$];
  mix_t want;
  int   fail_count = 0;
  int   frames_sent = 0;
  int   mixes_checked = 0;
  int   settings_used = 0;
  int   stall_left = 0;
  bit   idle_enabled = 1'b1;

  crossfade_channel_switch uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input longint x);
    longint hi;
    longint lo;
    longint y;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    y = x;
    if (y > hi) begin
      y = hi;
    end else if (y < lo) begin
      y = lo;
    end
    return y[SAMPLE_BITS-1:0];
  endfunction

  // advance the selection and gains by one beat, then weight the samples
  function automatic mix_t slew_and_mix(input frame_t f);
    logic [CHANNELS-1:0] rising;
    longint acc;
    longint smp_ext;
    mix_t m;
    rising = f.buttons & ~buttons_prev;
    buttons_prev = f.buttons;
    for (int i = 0; i < CHANNELS; i++) begin
      if (rising[i]) pick = SEL_W'(i);
    end
    for (int i = 0; i < CHANNELS; i++) begin
      if (i == pick) begin
        gain_q16[i] = (GAIN_ONE - gain_q16[i] > step_now) ? gain_q16[i] + step_now : GAIN_ONE;
      end else begin
        gain_q16[i] = (gain_q16[i] > step_now) ? gain_q16[i] - step_now : 0;
      end
    end
    m = '0;
    acc = 0;
    if (direction_now == DIR_MUX) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smp_ext = $signed(f.smp[i]);
        acc += (smp_ext * gain_q16[i]) >>> GAIN_FRAC_BITS;
      end
      m.outs[0] = clamp_sample(acc);
    end else begin
      smp_ext = $signed(f.smp[0]);
      for (int i = 0; i < CHANNELS; i++) begin
        m.outs[i] = clamp_sample((smp_ext * gain_q16[i]) >>> GAIN_FRAC_BITS);
      end
    end
    m.sel = pick;
    return m;
  endfunction

  function automatic frame_t make_frame(input logic [CHANNELS-1:0] buttons,
                                        input logic [SAMPLE_BITS-1:0] s0,
                                        input logic [SAMPLE_BITS-1:0] rest);
    frame_t f;
    f.buttons = buttons;
    f.smp[0] = s0;
    for (int i = 1; i < CHANNELS; i++) f.smp[i] = rest;
    return f;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endtask

  // one beat on the input side; valid stays high into the next call when no gap follows
  task automatic send_frame(input frame_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(f.smp);
    in_tuser  <= f.buttons;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_mix.push_back(slew_and_mix(f));
    frames_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_settings(input logic dir, input int step);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIRECTION;
    cfg_wdata <= CFG_DATA_W'(dir);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLEW_STEP;
    cfg_wdata <= CFG_DATA_W'(step);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    direction_now = dir;
    step_now = step;
    settings_used++;
  endtask

  // reset values: mux, slow slew, channel 0 ramping up from silence
  task automatic test_reset_state();
    send_frame(make_frame('0, SMP_MAX, SMP_MAX));
    send_frame(make_frame('0, SMP_MIN, SMP_MIN));
    send_frame(make_frame('0, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom)));
  endtask

  // demux with full-scale step so every edge shows at once on the outputs
  task automatic test_select_edges();
    write_settings(DIR_DEMUX, GAIN_ONE);
    send_frame(make_frame(5'b11111, SMP_MAX, '0));   // all rise, highest wins
    send_frame(make_frame(5'b11111, SMP_MIN, '0));   // held, no edge
    send_frame(make_frame(5'b00000, '1, '0));        // release keeps selection
    send_frame(make_frame(5'b00001, SMP_MAX, SMP_MIN));
    send_frame(make_frame(5'b00110, SMP_MIN, SMP_MAX));
    send_frame(make_frame(5'b00111, SMP_MAX, '1));   // only bit 0 rises
    send_frame(make_frame(5'b10000, '1, SMP_MAX));
    send_frame(make_frame(5'b01000, '0, SMP_MIN));
  endtask

  task automatic test_mux_extremes();
    write_settings(DIR_MUX, 1);
    send_frame(make_frame(5'b00010, SMP_MAX, SMP_MAX));
    send_frame(make_frame(5'b00010, SMP_MIN, SMP_MIN));
    send_frame(make_frame(5'b00000, SMP_MAX, SMP_MIN));
    send_frame(make_frame(5'b00000, '1, '1));
    // quick switching leaves several gains partly open
    write_settings(DIR_MUX, 20000);
    send_frame(make_frame(5'b00001, SMP_MAX, SMP_MAX));
    send_frame(make_frame(5'b00011, SMP_MIN, SMP_MIN));
    send_frame(make_frame(5'b00111, SMP_MAX, SMP_MIN));
    send_frame(make_frame(5'b01111, SMP_MIN, SMP_MIN));
    send_frame(make_frame(5'b11111, SMP_MAX, SMP_MAX));
    send_frame(make_frame(5'b00000, SMP_MIN, SMP_MAX));
  endtask

  task automatic test_random_settings();
    int steps [8] = '{34, GAIN_ONE, 0, 1, 4096, 0, GAIN_ONE, 700};
    logic [CHANNELS-1:0] held;
    frame_t f;
    int r;
    int k;
    int step;
    held = buttons_prev;
    for (int ph = 0; ph < 8; ph++) begin
      step = (steps[ph] == 0) ? $urandom_range(1, GAIN_ONE) : steps[ph];
      write_settings((ph % 2 == 0) ? DIR_MUX : DIR_DEMUX, step);
      idle_enabled = (ph % 3 != 2);
      for (int n = 0; n < 50; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          f.buttons = held;
        end else if (r < 75) begin
          f.buttons = CHANNELS'($urandom);
        end else if (r < 92) begin
          f.buttons = CHANNELS'(1) << $urandom_range(0, CHANNELS - 1);
        end else begin
          f.buttons = '0;
        end
        held = f.buttons;
        for (int i = 0; i < CHANNELS; i++) begin
          k = $urandom_range(0, 99);
          if (k < 80) f.smp[i] = SAMPLE_BITS'($urandom);
          else if (k < 87) f.smp[i] = SMP_MAX;
          else if (k < 94) f.smp[i] = SMP_MIN;
          else f.smp[i] = (k % 2 == 0) ? '0 : '1;
        end
        send_frame(f);
      end
    end
    idle_enabled = 1'b1;
  endtask

  // result side: compare each beat, then pace out_tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_mix.size() == 0) begin
        report_mismatch("unexpected beat, selected", -1, longint'(out_tuser));
      end else begin
        want = expected_mix.pop_front();
        mixes_checked++;
        for (int i = 0; i < CHANNELS; i++) begin
          if (out_tdata[i*SAMPLE_BITS +: SAMPLE_BITS] !== want.outs[i]) begin
            report_mismatch($sformatf("out_%0d", i), longint'($signed(want.outs[i])),
                            longint'($signed(out_tdata[i*SAMPLE_BITS +: SAMPLE_BITS])));
          end
        end
        if (out_tuser !== want.sel) begin
          report_mismatch("selected", longint'(want.sel), longint'(out_tuser));
        end
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rst_n && idle_enabled && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #2000000;
    $display("crossfade_channel_switch test failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_select_edges();
    test_mux_extremes();
    test_random_settings();
    settle();
    repeat (10) @(posedge clk);
    $display("%0d beats sent across %0d register settings, both directions", frames_sent,
             settings_used);
    $display("%0d results compared, %0d mismatches", mixes_checked, fail_count);
    if (fail_count == 0) begin
      $display("crossfade_channel_switch test passed");
    end else begin
      $display("crossfade_channel_switch test failed");
    end
    $finish;
  end

endmodule

### crossfade_channel_switch.f
rtl/cfcs_pkg.sv
rtl/cfcs_front.sv
rtl/cfcs_queue.sv
rtl/cfcs_back.sv
rtl/crossfade_channel_switch.sv
tb/crossfade_channel_switch_test.sv
